// ===== hw/rtl/ata_taskfile_command_issue_top_assert.svh =====
// Assertion macros shared by the task-file command issue RTL.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef ATA_TASKFILE_COMMAND_ISSUE_TOP_ASSERT_SVH
`define ATA_TASKFILE_COMMAND_ISSUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATA_TF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ata task-file assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ATA_TF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ata task-file assertion failed");

`endif

// ===== hw/rtl/ata_tf_pkg.sv =====
// Package for the task-file command issue block: types, register codes, command bytes
// and the function that maps a sequencer step to one task-file write. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ata_tf_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int SLOT_MAP_W = 4;
  localparam int CMDQ_DEPTH = 2;
  localparam int STEP_W     = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_MAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LBA_MAP     = 2'd2;

  localparam logic [3:0] REG_SECCOUNT0 = 4'd2;
  localparam logic [3:0] REG_LBA0      = 4'd3;
  localparam logic [3:0] REG_LBA1      = 4'd4;
  localparam logic [3:0] REG_LBA2      = 4'd5;
  localparam logic [3:0] REG_DEVSEL    = 4'd6;
  localparam logic [3:0] REG_COMMAND   = 4'd7;
  localparam logic [3:0] REG_SECCOUNT1 = 4'd8;
  localparam logic [3:0] REG_LBA3      = 4'd9;
  localparam logic [3:0] REG_LBA4      = 4'd10;
  localparam logic [3:0] REG_LBA5      = 4'd11;
  localparam logic [3:0] REG_CONTROL   = 4'd12;

  localparam logic [7:0] DEVSEL_CHS = 8'hA0;
  localparam logic [7:0] DEVSEL_LBA = 8'hE0;
  localparam logic [7:0] CTRL_NIEN  = 8'h02;
  localparam logic [7:0] CTRL_HOB   = 8'h82;
  localparam logic [7:0] CMD_RD     = 8'h20;
  localparam logic [7:0] CMD_RD_EXT = 8'h24;
  localparam logic [7:0] CMD_WR     = 8'h30;
  localparam logic [7:0] CMD_WR_EXT = 8'h34;

  // floor(2^34 / 63); the estimate it gives is at most one below the true quotient.
  localparam logic [28:0] RECIP_63    = 29'd272696336;
  localparam int          RECIP_SHIFT = 34;
  localparam logic [6:0]  CHS_SECTORS = 7'd63;

  localparam logic [STEP_W-1:0] STEP_LAST_LBA48 = 5'd18;
  localparam logic [STEP_W-1:0] STEP_LAST_SHORT = 5'd6;
  localparam logic [STEP_W-1:0] STEP_SKIP_HOB   = 5'd12;

  typedef enum logic [1:0] {
    MODE_CHS   = 2'd0,
    MODE_LBA28 = 2'd1,
    MODE_LBA48 = 2'd2
  } mode_t;

  typedef struct packed {
    logic       chan;
    mode_t      mode;
    logic [7:0] devsel;
    logic [7:0] count;
    logic [7:0] a0;
    logic [7:0] a1;
    logic [7:0] a2;
    logic [7:0] a3;
    logic [7:0] cmd;
  } desc_t;

  typedef struct packed {
    logic       chan;
    logic [3:0] reg_idx;
    logic [7:0] data;
    mode_t      mode;
    logic       last;
  } wr_t;

  // Steps follow the LBA48 run; shorter runs skip the high-order steps 2 to 13.
  function automatic wr_t step_write(input desc_t d, input logic [STEP_W-1:0] s);
    wr_t w;
    w.chan    = d.chan;
    w.mode    = d.mode;
    w.last    = 1'b0;
    w.reg_idx = REG_CONTROL;
    w.data    = CTRL_NIEN;
    unique case (s)
      5'd1: begin
        w.reg_idx = REG_DEVSEL;
        w.data    = d.devsel;
      end
      5'd2, 5'd5, 5'd8, 5'd11: begin
        w.data = CTRL_HOB;
      end
      5'd3: begin
        w.reg_idx = REG_SECCOUNT1;
        w.data    = 8'h00;
      end
      5'd6: begin
        w.reg_idx = REG_LBA3;
        w.data    = d.a3;
      end
      5'd9: begin
        w.reg_idx = REG_LBA4;
        w.data    = 8'h00;
      end
      5'd12: begin
        w.reg_idx = REG_LBA5;
        w.data    = 8'h00;
      end
      5'd14: begin
        w.reg_idx = REG_SECCOUNT0;
        w.data    = d.count;
      end
      5'd15: begin
        w.reg_idx = REG_LBA0;
        w.data    = d.a0;
      end
      5'd16: begin
        w.reg_idx = REG_LBA1;
        w.data    = d.a1;
      end
      5'd17: begin
        w.reg_idx = REG_LBA2;
        w.data    = d.a2;
      end
      5'd18: begin
        w.reg_idx = REG_COMMAND;
        w.data    = d.cmd;
        w.last    = 1'b1;
      end
      default: begin
        w.reg_idx = REG_CONTROL;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ata_tf_req_if.sv =====
// Request channel interface: valid/ready handshake with one sector-access request.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ata_tf_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [1:0]  drive_slot;
  logic [31:0] block_address;
  logic [7:0]  sector_total;

  modport source (output valid, operation, drive_slot, block_address, sector_total,
                  input ready);
  modport sink (input valid, operation, drive_slot, block_address, sector_total,
                output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ata_tf_wr_if.sv =====
// Result channel interface: valid/ready handshake with one task-file register write.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ata_tf_wr_if;
  logic       valid;
  logic       ready;
  logic       bus_channel;
  logic [3:0] register_index;
  logic [7:0] write_byte;
  logic [1:0] address_mode;
  logic       run_last;

  modport source (output valid, bus_channel, register_index, write_byte, address_mode,
                  run_last, input ready);
  modport sink (input valid, bus_channel, register_index, write_byte, address_mode,
                run_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ata_tf_front.sv =====
// Front end: drive map registers, request capture and address classification.
// Depends on ata_tf_pkg and ata_tf_req_if; produces one command descriptor per request.
`timescale 1ns / 1ps
`default_nettype none

module ata_tf_front #(
  parameter int DRIVE_SLOTS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ata_tf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ata_tf_pkg::CFG_DATA_W-1:0] cfg_data,
  ata_tf_req_if.sink                       req,
  output logic                             push_valid,
  output ata_tf_pkg::desc_t                push_desc,
  input  logic                             q_full
);

  logic [DRIVE_SLOTS-1:0] chan_map_r;
  logic [DRIVE_SLOTS-1:0] slave_map_r;
  logic [DRIVE_SLOTS-1:0] lba_map_r;

  logic [ata_tf_pkg::SLOT_MAP_W-1:0] chan_ext;
  logic [ata_tf_pkg::SLOT_MAP_W-1:0] slave_ext;
  logic [ata_tf_pkg::SLOT_MAP_W-1:0] lba_ext;

  logic        accept;
  logic        a_valid_r;
  logic        a_valid_nxt;
  logic        a_op_r;
  logic        a_chan_r;
  logic        a_slave_r;
  logic        a_lbacap_r;
  logic [31:0] a_lba_r;
  logic [7:0]  a_count_r;
  logic [56:0] a_prod_r;
  logic [56:0] a_prod_nxt;

  logic [21:0] q_est;
  logic [21:0] q_fix;
  logic [27:0] q_times63;
  logic [27:0] r_est;
  logic [6:0]  r_fix;
  logic [15:0] cyl;
  logic [3:0]  head;
  logic        is_lba48;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_map_r  <= '0;
      slave_map_r <= '0;
      lba_map_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ata_tf_pkg::CFG_CHANNEL_MAP: chan_map_r  <= cfg_data[DRIVE_SLOTS-1:0];
        ata_tf_pkg::CFG_SLAVE_MAP:   slave_map_r <= cfg_data[DRIVE_SLOTS-1:0];
        ata_tf_pkg::CFG_LBA_MAP:     lba_map_r   <= cfg_data[DRIVE_SLOTS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Slots past the configured count read as zero through the extension.
  assign chan_ext  = ata_tf_pkg::SLOT_MAP_W'(chan_map_r);
  assign slave_ext = ata_tf_pkg::SLOT_MAP_W'(slave_map_r);
  assign lba_ext   = ata_tf_pkg::SLOT_MAP_W'(lba_map_r);

  assign req.ready   = !a_valid_r || !q_full;
  assign accept      = req.valid && req.ready;
  assign a_valid_nxt = accept || (a_valid_r && q_full);
  assign a_prod_nxt  = req.block_address[27:0] * ata_tf_pkg::RECIP_63;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_op_r     <= req.operation;
      a_chan_r   <= chan_ext[req.drive_slot];
      a_slave_r  <= slave_ext[req.drive_slot];
      a_lbacap_r <= lba_ext[req.drive_slot];
      a_lba_r    <= req.block_address;
      a_count_r  <= req.sector_total;
      a_prod_r   <= a_prod_nxt;
    end
  end

  // CHS: q = lba / 63, sector = remainder + 1, cylinder = q / 16, head = q % 16.
  assign q_est     = a_prod_r[ata_tf_pkg::RECIP_SHIFT+21:ata_tf_pkg::RECIP_SHIFT];
  assign q_times63 = {q_est, 6'b0} - {6'b0, q_est};
  assign r_est     = a_lba_r[27:0] - q_times63;

  always_comb begin
    if (r_est[6:0] >= ata_tf_pkg::CHS_SECTORS) begin
      q_fix = q_est + 22'd1;
      r_fix = r_est[6:0] - ata_tf_pkg::CHS_SECTORS;
    end else begin
      q_fix = q_est;
      r_fix = r_est[6:0];
    end
  end

  assign cyl      = q_fix[19:4];
  assign is_lba48 = |a_lba_r[31:28];

  always_comb begin
    push_desc.chan  = a_chan_r;
    push_desc.count = a_count_r;
    push_desc.a3    = 8'h00;
    priority if (is_lba48) begin
      push_desc.mode = ata_tf_pkg::MODE_LBA48;
      push_desc.a0   = a_lba_r[7:0];
      push_desc.a1   = a_lba_r[15:8];
      push_desc.a2   = a_lba_r[23:16];
      push_desc.a3   = a_lba_r[31:24];
      head           = 4'd0;
    end else if (a_lbacap_r) begin
      push_desc.mode = ata_tf_pkg::MODE_LBA28;
      push_desc.a0   = a_lba_r[7:0];
      push_desc.a1   = a_lba_r[15:8];
      push_desc.a2   = a_lba_r[23:16];
      head           = a_lba_r[27:24];
    end else begin
      push_desc.mode = ata_tf_pkg::MODE_CHS;
      push_desc.a0   = {1'b0, r_fix} + 8'd1;
      push_desc.a1   = cyl[7:0];
      push_desc.a2   = cyl[15:8];
      head           = q_fix[3:0];
    end
    push_desc.devsel = ((push_desc.mode == ata_tf_pkg::MODE_CHS) ?
                        ata_tf_pkg::DEVSEL_CHS : ata_tf_pkg::DEVSEL_LBA) |
                       {3'b000, a_slave_r, head};
    if (push_desc.mode == ata_tf_pkg::MODE_LBA48) begin
      push_desc.cmd = a_op_r ? ata_tf_pkg::CMD_WR_EXT : ata_tf_pkg::CMD_RD_EXT;
    end else begin
      push_desc.cmd = a_op_r ? ata_tf_pkg::CMD_WR : ata_tf_pkg::CMD_RD;
    end
  end

  assign push_valid = a_valid_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ata_tf_cmdq.sv =====
// Two-entry command queue between the front end and the write sequencer.
// Depends on ata_tf_pkg for the descriptor type and depth.
`timescale 1ns / 1ps
`default_nettype none

module ata_tf_cmdq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  ata_tf_pkg::desc_t push_desc,
  output logic              full,
  output logic              head_valid,
  output ata_tf_pkg::desc_t head,
  input  logic              pop
);

  localparam int PTR_W = $clog2(ata_tf_pkg::CMDQ_DEPTH);
  localparam int CNT_W = $clog2(ata_tf_pkg::CMDQ_DEPTH + 1);

  ata_tf_pkg::desc_t entry_r [ata_tf_pkg::CMDQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              push;

  assign full       = (count_r == CNT_W'(ata_tf_pkg::CMDQ_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];
  assign push       = push_valid && !full;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ata_tf_seq.sv =====
// Back end: steps through the queue head's register-write run into an output register,
// one write per cycle unless stalled. Uses ata_tf_pkg, ata_tf_wr_if, assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "ata_taskfile_command_issue_top_assert.svh"

module ata_tf_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  ata_tf_pkg::desc_t head,
  output logic              pop,
  ata_tf_wr_if.source       wr
);

  logic [ata_tf_pkg::STEP_W-1:0] step_r;
  logic [ata_tf_pkg::STEP_W-1:0] step_nxt;
  logic [ata_tf_pkg::STEP_W-1:0] eff_step;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  ata_tf_pkg::wr_t               out_q_r;
  ata_tf_pkg::wr_t               cur_wr;
  logic                          advance;
  logic                          issue;

  assign advance = !out_valid_r || wr.ready;
  assign issue   = advance && head_valid;

  always_comb begin
    if (head.mode == ata_tf_pkg::MODE_LBA48 || step_r < 5'd2) begin
      eff_step = step_r;
    end else begin
      eff_step = step_r + ata_tf_pkg::STEP_SKIP_HOB;
    end
  end

  assign cur_wr = ata_tf_pkg::step_write(head, eff_step);
  assign pop    = issue && cur_wr.last;

  always_comb begin
    step_nxt = step_r;
    if (issue) begin
      step_nxt = cur_wr.last ? '0 : step_r + 5'd1;
    end
  end

  assign out_valid_nxt = issue || (out_valid_r && !wr.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_q_r <= cur_wr;
    end
  end

  assign wr.valid          = out_valid_r;
  assign wr.bus_channel    = out_q_r.chan;
  assign wr.register_index = out_q_r.reg_idx;
  assign wr.write_byte     = out_q_r.data;
  assign wr.address_mode   = 2'(out_q_r.mode);
  assign wr.run_last       = out_q_r.last;

  `ATA_TF_ASSERT_IMPL(a_last_is_command, out_valid_r && out_q_r.last,
                      out_q_r.reg_idx == ata_tf_pkg::REG_COMMAND)
  `ATA_TF_ASSERT_IMPL(a_mid_run_has_head, step_r != '0, head_valid)
  `ATA_TF_ASSERT_IMPL(a_short_run_bound, head_valid && head.mode != ata_tf_pkg::MODE_LBA48,
                      step_r <= ata_tf_pkg::STEP_LAST_SHORT)
  `ATA_TF_ASSERT_IMPL(a_long_run_bound, head_valid,
                      step_r <= ata_tf_pkg::STEP_LAST_LBA48)

endmodule

`default_nettype wire

// ===== hw/rtl/ata_taskfile_command_issue_top.sv =====
// ATA task-file command issue: one request in, a run of 19 (LBA48) or 7 register writes out.
// A request is registered in the front end, then queued; its first write is registered
// at the sequencer output. Writes leave at one per cycle unless the output stalls; the
// write sequencer sets this rate, and a two-entry queue lets the front end run ahead.
// Reset is synchronous and active low: drive maps clear to zero and all queues empty.
// Depends on ata_tf_pkg, both channel interfaces, ata_tf_front, ata_tf_cmdq, ata_tf_seq.
`timescale 1ns / 1ps
`default_nettype none

module ata_taskfile_command_issue_top #(
  parameter int DRIVE_SLOTS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ata_tf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ata_tf_pkg::CFG_DATA_W-1:0] cfg_data,
  ata_tf_req_if.sink                       in_req,
  ata_tf_wr_if.source                      out_wr
);

  logic              push_valid;
  ata_tf_pkg::desc_t push_desc;
  logic              q_full;
  logic              head_valid;
  ata_tf_pkg::desc_t head;
  logic              pop;

  ata_tf_front #(
    .DRIVE_SLOTS(DRIVE_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (in_req),
    .push_valid(push_valid),
    .push_desc (push_desc),
    .q_full    (q_full)
  );

  ata_tf_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_desc (push_desc),
    .full      (q_full),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  ata_tf_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .wr        (out_wr)
  );

endmodule

`default_nettype wire
